@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/sbmq_pkg.sv @@
// constants, types and helpers of the shared buffer multi queue
`default_nettype none

package sbmq_pkg;

    localparam int DEPTH      = 16;
    localparam int NUM_QUEUES = 4;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int PTR_W      = IDX_W + 1;
    localparam int Q_W        = $clog2(NUM_QUEUES);

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [Q_W-1:0]   t_qid;

    // pointer value that marks an empty list
    localparam t_ptr NIL = t_ptr'(DEPTH);

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    function automatic logic is_entry(input t_ptr p);
        return p < NIL;
    endfunction

endpackage

`default_nettype wire

@@ src/sbmq_req_if.sv @@
// request channel: operation, queue number and value
`default_nettype none

interface sbmq_req_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    sbmq_pkg::t_qid            queue_id;
    logic signed [sbmq_pkg::DATA_W-1:0] data_in;

    modport source (output valid, output func, output queue_id, output data_in, input ready);
    modport sink   (input valid, input func, input queue_id, input data_in, output ready);
endinterface

`default_nettype wire

@@ src/sbmq_rsp_if.sv @@
// response channel: status and dequeued value
`default_nettype none

interface sbmq_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      ok;
    logic signed [sbmq_pkg::DATA_W-1:0] data_out;

    modport source (output valid, output ok, output data_out, input ready);
    modport sink   (input valid, input ok, input data_out, output ready);
endinterface

`default_nettype wire

@@ src/shared_buffer_multi_queue.sv @@
// several fifo queues linked through one shared item store with a free list
//
// Takes one enqueue or dequeue request and answers with one item carrying ok
// and the dequeued value (zero on enqueue or failure). Each request has an
// accept step, where the free pointer or the queue head selects the entry and
// the item and link memories are read, and an execute step, where the pointers
// are rebuilt and at most one link write and one item write go back to memory.
// No new request is taken until the execute step ends, which waits only while
// the previous result is still held in the output register. Link entries carry
// valid bits that reset clears, so the block is usable right after reset with no
// clearing pass. A failed request (full store, empty queue) changes no state.
`default_nettype none

module shared_buffer_multi_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sbmq_req_if.sink    i_req,
    sbmq_rsp_if.source  o_rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    sbmq_pkg::t_ptr r_head [sbmq_pkg::NUM_QUEUES];
    sbmq_pkg::t_ptr r_tail [sbmq_pkg::NUM_QUEUES];
    sbmq_pkg::t_ptr r_free;
    logic [sbmq_pkg::DEPTH-1:0] r_link_vld;

    logic signed [sbmq_pkg::DATA_W-1:0] item_mem [sbmq_pkg::DEPTH];
    sbmq_pkg::t_ptr                     link_mem [sbmq_pkg::DEPTH];

    logic signed [sbmq_pkg::DATA_W-1:0] r_item_rdata;
    sbmq_pkg::t_ptr                     r_link_rdata;
    logic                               r_link_rvld;
    sbmq_pkg::t_idx                     r_raddr;

    logic                               r_func;
    sbmq_pkg::t_qid                     r_q;
    logic signed [sbmq_pkg::DATA_W-1:0] r_data;
    sbmq_pkg::t_ptr                     r_slot;

    logic                               r_out_valid;
    logic                               r_out_ok;
    logic signed [sbmq_pkg::DATA_W-1:0] r_out_data;

    logic           accept;
    sbmq_pkg::t_ptr slot_sel;
    logic           commit;
    sbmq_pkg::t_ptr nxt;
    sbmq_pkg::t_ptr nxt_norm;
    sbmq_pkg::t_ptr cur_head;
    sbmq_pkg::t_ptr cur_tail;
    logic           slot_ok;
    logic           q_empty;
    logic           enq_ok;
    logic           deq_ok;
    logic           link_we;
    sbmq_pkg::t_idx link_waddr;
    sbmq_pkg::t_ptr link_wdata;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign slot_sel    = (i_req.func == sbmq_pkg::FUNC_DEQ) ? r_head[i_req.queue_id] : r_free;

    // read both memories at the chosen entry
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item_rdata <= item_mem[slot_sel[sbmq_pkg::IDX_W-1:0]];
            r_link_rdata <= link_mem[slot_sel[sbmq_pkg::IDX_W-1:0]];
            r_link_rvld  <= r_link_vld[slot_sel[sbmq_pkg::IDX_W-1:0]];
            r_raddr      <= slot_sel[sbmq_pkg::IDX_W-1:0];
            r_func       <= i_req.func;
            r_q          <= i_req.queue_id;
            r_data       <= i_req.data_in;
            r_slot       <= slot_sel;
        end
    end

    assign commit   = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);
    // an unwritten link (valid bit clear) reads as its reset chain value, entry plus one
    assign nxt      = r_link_rvld ? r_link_rdata
                                  : sbmq_pkg::t_ptr'(r_raddr) + sbmq_pkg::t_ptr'(1);
    assign nxt_norm = sbmq_pkg::is_entry(nxt) ? nxt : sbmq_pkg::NIL;
    assign cur_head = r_head[r_q];
    assign cur_tail = r_tail[r_q];
    assign slot_ok  = sbmq_pkg::is_entry(r_slot);
    assign q_empty  = !sbmq_pkg::is_entry(cur_head) || !sbmq_pkg::is_entry(cur_tail);
    assign enq_ok   = commit && slot_ok && (r_func == sbmq_pkg::FUNC_ENQ);
    assign deq_ok   = commit && slot_ok && (r_func == sbmq_pkg::FUNC_DEQ);

    // the tail link is never followed, so an enqueue only links the old tail
    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_slot[sbmq_pkg::IDX_W-1:0];
        link_wdata = r_free;
        if (enq_ok && !q_empty) begin
            link_we    = 1'b1;
            link_waddr = cur_tail[sbmq_pkg::IDX_W-1:0];
            link_wdata = r_slot;
        end else if (deq_ok) begin
            link_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (enq_ok) begin
            item_mem[r_slot[sbmq_pkg::IDX_W-1:0]] <= r_data;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= '0;
            r_link_vld  <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < sbmq_pkg::NUM_QUEUES; i++) begin
                r_head[i] <= sbmq_pkg::NIL;
                r_tail[i] <= sbmq_pkg::NIL;
            end
        end else begin
            r_state <= n_state;
            if (link_we) begin
                r_link_vld[link_waddr] <= 1'b1;
            end
            if (enq_ok) begin
                r_free <= nxt_norm;
                if (q_empty) begin
                    r_head[r_q] <= r_slot;
                end
                r_tail[r_q] <= r_slot;
            end
            if (deq_ok) begin
                r_free <= r_slot;
                // the last entry of a queue leaves it empty
                if (r_slot == cur_tail) begin
                    r_head[r_q] <= sbmq_pkg::NIL;
                    r_tail[r_q] <= sbmq_pkg::NIL;
                end else begin
                    r_head[r_q] <= nxt_norm;
                end
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_ok   <= slot_ok;
            r_out_data <= (slot_ok && (r_func == sbmq_pkg::FUNC_DEQ)) ? r_item_rdata : '0;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.ok       = r_out_ok;
    assign o_rsp.data_out = r_out_data;

endmodule

`default_nettype wire

@@ src/sbmq_checker.sv @@
// port level checks of the shared buffer multi queue, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module sbmq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_req_valid,
    input logic                               i_req_ready,
    input logic                               i_rsp_valid,
    input logic                               i_rsp_ready,
    input logic                               i_rsp_ok,
    input logic signed [sbmq_pkg::DATA_W-1:0] i_rsp_data
);

    logic req_acc;
    logic rsp_acc;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    // a result item stays until taken
    `ASSERT_NEXT_CYCLE(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)
    // a failed operation shows no data
    `ASSERT_SAME_CYCLE(a_fail_zero, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ok, i_rsp_data == '0)
    // one item at a time: no request right after an accepted one
    `ASSERT_NEXT_CYCLE(a_one_busy, i_clk, i_rst_n, req_acc, !i_req_ready)
    // a fresh result follows an accepted request that was executed without a stall
    `ASSERT_SAME_CYCLE(a_rsp_cause, i_clk, i_rst_n, $rose(i_rsp_valid), $past(req_acc, 2))
    // a result taken with none waiting behind it leaves the channel empty
    `ASSERT_NEXT_CYCLE(a_rsp_drain, i_clk, i_rst_n, rsp_acc && i_req_ready, !i_rsp_valid)

endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_ok    (o_rsp.ok),
    .i_rsp_data  (o_rsp.data_out)
);

`default_nettype wire

@@ tb/testbench.sv @@
// testbench for the shared buffer multi queue: random and directed enqueue/dequeue traffic
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic                               func;
        sbmq_pkg::t_qid                     qid;
        logic signed [sbmq_pkg::DATA_W-1:0] value;
        int unsigned                        phase;
    } t_queue_request;

    typedef struct {
        logic                               ok;
        logic signed [sbmq_pkg::DATA_W-1:0] data;
    } t_queue_answer;

    localparam int RANDOM_TOTAL = 1275;

    logic i_clk;
    logic i_rst_n;

    sbmq_req_if req();
    sbmq_rsp_if rsp();

    shared_buffer_multi_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // idle percentages per phase: sender, then receiver
    int unsigned src_idle_pct[3]  = '{32, 86, 0};
    int unsigned sink_idle_pct[3] = '{86, 32, 0};

    t_queue_request queued_requests[$];
    t_queue_answer  pending_answers[$];
    t_queue_request on_bus;
    int unsigned    active_phase;
    int unsigned    mismatch_count;

    // shadow copy of the linked store
    logic signed [sbmq_pkg::DATA_W-1:0] item_mem[sbmq_pkg::DEPTH];
    sbmq_pkg::t_ptr                     link_mem[sbmq_pkg::DEPTH];
    sbmq_pkg::t_ptr                     head_ptr[sbmq_pkg::NUM_QUEUES];
    sbmq_pkg::t_ptr                     tail_ptr[sbmq_pkg::NUM_QUEUES];
    sbmq_pkg::t_ptr                     free_ptr;

    function automatic t_queue_answer model_queue_op(input t_queue_request r);
        t_queue_answer  a;
        sbmq_pkg::t_ptr slot;
        sbmq_pkg::t_ptr nxt;
        a.ok   = 1'b0;
        a.data = '0;
        if (int'(r.qid) < sbmq_pkg::NUM_QUEUES) begin
            if (r.func == sbmq_pkg::FUNC_ENQ) begin
                slot = free_ptr;
                if (slot < sbmq_pkg::NIL) begin
                    nxt      = link_mem[sbmq_pkg::t_idx'(slot)];
                    free_ptr = (nxt < sbmq_pkg::NIL) ? nxt : sbmq_pkg::NIL;
                    if (head_ptr[r.qid] < sbmq_pkg::NIL && tail_ptr[r.qid] < sbmq_pkg::NIL) begin
                        link_mem[sbmq_pkg::t_idx'(tail_ptr[r.qid])] = slot;
                    end else begin
                        head_ptr[r.qid] = slot;
                    end
                    tail_ptr[r.qid]                  = slot;
                    item_mem[sbmq_pkg::t_idx'(slot)] = r.value;
                    link_mem[sbmq_pkg::t_idx'(slot)] = sbmq_pkg::NIL;
                    a.ok                             = 1'b1;
                end
            end else begin
                slot = head_ptr[r.qid];
                if (slot < sbmq_pkg::NIL) begin
                    nxt             = link_mem[sbmq_pkg::t_idx'(slot)];
                    head_ptr[r.qid] = (nxt < sbmq_pkg::NIL) ? nxt : sbmq_pkg::NIL;
                    if (!(head_ptr[r.qid] < sbmq_pkg::NIL)) begin
                        tail_ptr[r.qid] = sbmq_pkg::NIL;
                    end
                    // freed entry goes to the front of the free list
                    link_mem[sbmq_pkg::t_idx'(slot)] = free_ptr;
                    free_ptr                         = slot;
                    a.data                           = item_mem[sbmq_pkg::t_idx'(slot)];
                    a.ok                             = 1'b1;
                end
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 200) begin
            $display("%0t ns: mismatch: %s", $realtime, what);
        end
    endtask

    task automatic push_request(input logic func, input sbmq_pkg::t_qid qid,
                                input logic signed [sbmq_pkg::DATA_W-1:0] value);
        t_queue_request r;
        int unsigned    n;
        n        = queued_requests.size();
        r.func   = func;
        r.qid    = qid;
        r.value  = value;
        r.phase  = (n < 420) ? 0 : (n < 840) ? 1 : 2;
        queued_requests.push_back(r);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // known values before the first edge
    initial begin
        i_rst_n      = 1'b0;
        req.valid    = 1'b0;
        req.func     = sbmq_pkg::FUNC_ENQ;
        req.queue_id = '0;
        req.data_in  = '0;
        rsp.ready    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver: holds an item until it is taken, then maybe idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req.valid <= 1'b0;
        end else begin
            if (req.valid && req.ready) begin
                pending_answers.push_back(model_queue_op(on_bus));
            end
            if (!req.valid || req.ready) begin
                if (queued_requests.size() != 0 &&
                    $urandom_range(99) >= src_idle_pct[queued_requests[0].phase]) begin
                    on_bus = queued_requests.pop_front();
                    req.valid    <= 1'b1;
                    req.func     <= on_bus.func;
                    req.queue_id <= on_bus.qid;
                    req.data_in  <= on_bus.value;
                    active_phase <= on_bus.phase;
                end else begin
                    req.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each answer against the oldest prediction
    always @(posedge i_clk) begin
        t_queue_answer want;
        if (!i_rst_n) begin
            rsp.ready <= 1'b0;
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch($sformatf("unexpected answer ok=%b data=%0d",
                                              rsp.ok, rsp.data_out));
                end else begin
                    want = pending_answers.pop_front();
                    if (rsp.ok !== want.ok) begin
                        report_mismatch($sformatf("ok %b, expected %b", rsp.ok, want.ok));
                    end
                    if (rsp.data_out !== want.data) begin
                        report_mismatch($sformatf("data_out %0d, expected %0d",
                                                  rsp.data_out, want.data));
                    end
                end
            end
            rsp.ready <= ($urandom_range(99) >= sink_idle_pct[active_phase]);
        end
    end

    initial begin
        logic                               heavy_func;
        logic                               func;
        sbmq_pkg::t_qid                     hot_q;
        sbmq_pkg::t_qid                     qid;
        int unsigned                        burst;
        logic signed [sbmq_pkg::DATA_W-1:0] value;

        mismatch_count = 0;
        active_phase   = 0;
        for (int i = 0; i < sbmq_pkg::DEPTH; i++) begin
            item_mem[i] = '0;
            link_mem[i] = (i + 1 < sbmq_pkg::DEPTH) ? sbmq_pkg::t_ptr'(i + 1) : sbmq_pkg::NIL;
        end
        for (int q = 0; q < sbmq_pkg::NUM_QUEUES; q++) begin
            head_ptr[q] = sbmq_pkg::NIL;
            tail_ptr[q] = sbmq_pkg::NIL;
        end
        free_ptr = '0;

        // every queue empty
        for (int q = 0; q < sbmq_pkg::NUM_QUEUES; q++) begin
            push_request(sbmq_pkg::FUNC_DEQ, sbmq_pkg::t_qid'(q), '0);
        end
        push_request(sbmq_pkg::FUNC_ENQ, sbmq_pkg::t_qid'(0), 32'sh7fff_ffff);
        push_request(sbmq_pkg::FUNC_ENQ, sbmq_pkg::t_qid'(0), 32'sh8000_0000);
        push_request(sbmq_pkg::FUNC_ENQ, sbmq_pkg::t_qid'(1), 32'sh0000_0000);
        push_request(sbmq_pkg::FUNC_ENQ, sbmq_pkg::t_qid'(1), -32'sd1);
        push_request(sbmq_pkg::FUNC_ENQ, sbmq_pkg::t_qid'(2), 32'sh5555_5555);
        push_request(sbmq_pkg::FUNC_ENQ, sbmq_pkg::t_qid'(3), 32'shaaaa_aaaa);
        // freed entry is reused by the next enqueue
        push_request(sbmq_pkg::FUNC_DEQ, sbmq_pkg::t_qid'(0), 32'sh1234_5678);
        // fill the store, then one enqueue too many
        for (int k = 0; k < sbmq_pkg::DEPTH - 5; k++) begin
            push_request(sbmq_pkg::FUNC_ENQ, sbmq_pkg::t_qid'(k % sbmq_pkg::NUM_QUEUES),
                         $urandom());
        end
        push_request(sbmq_pkg::FUNC_ENQ, sbmq_pkg::t_qid'(2), 32'sh0bad_0bad);
        push_request(sbmq_pkg::FUNC_DEQ, sbmq_pkg::t_qid'(0), '0);
        push_request(sbmq_pkg::FUNC_DEQ, sbmq_pkg::t_qid'(1), '0);

        // bursts leaning to enqueue or dequeue drive the store between full and empty
        while (queued_requests.size() < RANDOM_TOTAL) begin
            heavy_func = 1'($urandom_range(1));
            burst      = $urandom_range(1, 24);
            hot_q      = sbmq_pkg::t_qid'($urandom_range(sbmq_pkg::NUM_QUEUES - 1));
            repeat (burst) begin
                func = ($urandom_range(99) < 80) ? heavy_func : ~heavy_func;
                qid  = ($urandom_range(99) < 60)
                     ? hot_q
                     : sbmq_pkg::t_qid'($urandom_range(sbmq_pkg::NUM_QUEUES - 1));
                case ($urandom_range(15))
                    0:       value = 32'sh8000_0000;
                    1:       value = 32'sh7fff_ffff;
                    2:       value = '0;
                    3:       value = -32'sd1;
                    default: value = $urandom();
                endcase
                push_request(func, qid, value);
            end
        end

        // drain: sampled away from the active edge
        @(negedge i_clk);
        while (queued_requests.size() != 0 || req.valid || pending_answers.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (12) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            report_mismatch($sformatf("%0d answers never arrived", pending_answers.size()));
        end
        if (mismatch_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
